// ===== sv/pame_pkg.sv =====
`timescale 1ns / 1ps
package pame_pkg;

  localparam int MAX_EXPONENT = 255;
  localparam int COEF_BITS    = 16;

  localparam int NEXP  = MAX_EXPONENT + 1;
  localparam int NPROD = 2 * MAX_EXPONENT + 1;

  localparam int FA_W  = $clog2(NEXP);
  localparam int PA_W  = $clog2(NPROD);
  localparam int PTR_W = PA_W + 1;
  localparam int CNT_W = FA_W + 1;

  localparam int IN_COEF_W = 16;
  localparam int IN_EXP_W  = 8;
  localparam int TC_W      = 40;
  localparam int TE_W      = 9;
  localparam int CMD_W     = 3;

  localparam int D_W   = COEF_BITS + 1;
  localparam int MUL_W = D_W + COEF_BITS;

  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_1    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_2    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ_PROD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ_SUM  = 3'd4;

  typedef struct packed {
    logic            we;
    logic [PA_W-1:0] addr;
    logic [TC_W-1:0] data;
  } prod_wr_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLR   = 6'b000010,
    S_LDRD  = 6'b000100,
    S_LDD   = 6'b001000,
    S_LDRUN = 6'b010000,
    S_SCAN  = 6'b100000
  } state_t;

endpackage

// ===== sv/pame_ram.sv =====
`timescale 1ns / 1ps
module pame_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pame_mac.sv =====
`timescale 1ns / 1ps
module pame_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  issue,
  input  logic [pame_pkg::PA_W-1:0]             issue_addr,
  input  logic signed [pame_pkg::D_W-1:0]       d,
  input  logic signed [pame_pkg::COEF_BITS-1:0] other_q,
  input  logic [pame_pkg::TC_W-1:0]             prod_q,
  output pame_pkg::prod_wr_t                    wr,
  output logic                                  active
);

  logic                                s1_v;
  logic [pame_pkg::PA_W-1:0]           s1_addr;
  logic                                s2_v;
  logic [pame_pkg::PA_W-1:0]           s2_addr;
  logic signed [pame_pkg::MUL_W-1:0]   mult;
  logic [pame_pkg::TC_W-1:0]           prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= issue;
      s2_v <= s1_v;
    end
    s1_addr <= issue_addr;
    s2_addr <= s1_addr;
    mult    <= d * other_q;
    prod    <= prod_q;
  end

  always_comb begin
    wr.we   = s2_v;
    wr.addr = s2_addr;
    wr.data = prod + pame_pkg::TC_W'(mult);
  end

  assign active = s1_v | s2_v;

endmodule

// ===== sv/polynomial_add_multiply_engine.sv =====
`timescale 1ns / 1ps
// Polynomial engine: two coefficient stores and a product store, each a single-port-read RAM.
// After reset and after a clear command busy stays high while the stores are swept to zero.
// A load walks the other store one entry per cycle through its read port into the
// multiply-accumulate pipeline. A read scans the store one entry per cycle from the cursor
// down, wrapping to the top of the store at most once. Results appear for one cycle on valid
// and cannot be held off by the receiver; loads, clears and unused commands give no word.
module polynomial_add_multiply_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [pame_pkg::CMD_W-1:0]            command,
  input  logic signed [pame_pkg::IN_COEF_W-1:0] coefficient,
  input  logic [pame_pkg::IN_EXP_W-1:0]         exponent,
  output logic                                  valid,
  output logic                                  source,
  output logic signed [pame_pkg::TC_W-1:0]      term_coefficient,
  output logic [pame_pkg::TE_W-1:0]             term_exponent,
  output logic                                  last_term,
  output logic                                  empty_poly
);

  pame_pkg::state_t state;

  logic                                   into_second;
  logic signed [pame_pkg::COEF_BITS-1:0]  coef_q;
  logic [pame_pkg::IN_EXP_W-1:0]          exp_q;
  logic signed [pame_pkg::D_W-1:0]        d;
  logic [pame_pkg::CNT_W-1:0]             j;
  logic [pame_pkg::PA_W-1:0]              clr_addr;
  logic [pame_pkg::PA_W-1:0]              prod_cur;
  logic [pame_pkg::FA_W-1:0]              sum_cur;

  logic                                   is_sum;
  logic                                   can_wrap;
  logic                                   wrapped;
  logic                                   found;
  logic [pame_pkg::PTR_W-1:0]             ptr;
  logic                                   chk_v;
  logic [pame_pkg::PA_W-1:0]              chk_addr;
  logic [pame_pkg::TC_W-1:0]              hold_coef;
  logic [pame_pkg::PA_W-1:0]              hold_exp;

  logic                                   f_we, s_we;
  logic [pame_pkg::FA_W-1:0]              fs_waddr, fs_raddr;
  logic [pame_pkg::COEF_BITS-1:0]         fs_wdata, f_q, s_q;
  logic                                   p_we;
  logic [pame_pkg::PA_W-1:0]              p_waddr, p_raddr;
  logic [pame_pkg::TC_W-1:0]              p_wdata, p_q;

  logic signed [pame_pkg::COEF_BITS-1:0]  c_in;
  logic                                   ld_issue;
  logic signed [pame_pkg::COEF_BITS-1:0]  other_q;
  logic signed [pame_pkg::COEF_BITS-1:0]  mine_q;
  logic signed [pame_pkg::D_W-1:0]        sum_w;
  logic [pame_pkg::TC_W-1:0]              chk_val;
  logic                                   chk_nz;
  logic                                   ptr_neg;
  pame_pkg::prod_wr_t                     mac_wr;
  logic                                   mac_active;

  assign busy     = (state != pame_pkg::S_IDLE);
  assign c_in     = coefficient[pame_pkg::COEF_BITS-1:0];
  assign ld_issue = (int'(j) < pame_pkg::NEXP);
  assign other_q  = into_second ? $signed(f_q) : $signed(s_q);
  assign mine_q   = into_second ? $signed(s_q) : $signed(f_q);
  assign sum_w    = pame_pkg::D_W'($signed(f_q)) + pame_pkg::D_W'($signed(s_q));
  assign chk_val  = is_sum ? pame_pkg::TC_W'(sum_w) : p_q;
  assign chk_nz   = (chk_val != '0);
  assign ptr_neg  = ptr[pame_pkg::PTR_W-1];

  // store port selection
  always_comb begin
    f_we     = 1'b0;
    s_we     = 1'b0;
    fs_waddr = pame_pkg::FA_W'(exp_q);
    fs_wdata = coef_q;
    fs_raddr = pame_pkg::FA_W'(exp_q);
    p_we     = mac_wr.we;
    p_waddr  = mac_wr.addr;
    p_wdata  = mac_wr.data;
    p_raddr  = pame_pkg::PA_W'(exp_q) + pame_pkg::PA_W'(j[pame_pkg::FA_W-1:0]);
    unique case (state)
      pame_pkg::S_CLR: begin
        f_we     = (int'(clr_addr) < pame_pkg::NEXP);
        s_we     = (int'(clr_addr) < pame_pkg::NEXP);
        fs_waddr = pame_pkg::FA_W'(clr_addr);
        fs_wdata = '0;
        p_we     = 1'b1;
        p_waddr  = clr_addr;
        p_wdata  = '0;
      end
      pame_pkg::S_LDD: begin
        f_we = !into_second;
        s_we = into_second;
      end
      pame_pkg::S_LDRUN: begin
        fs_raddr = j[pame_pkg::FA_W-1:0];
      end
      pame_pkg::S_SCAN: begin
        fs_raddr = pame_pkg::FA_W'(ptr);
        p_raddr  = pame_pkg::PA_W'(ptr);
      end
      default: begin
      end
    endcase
  end

  pame_ram #(.WIDTH(pame_pkg::COEF_BITS), .DEPTH(pame_pkg::NEXP)) u_first (
    .clk(clk), .we(f_we), .waddr(fs_waddr), .wdata(fs_wdata), .raddr(fs_raddr), .rdata(f_q)
  );

  pame_ram #(.WIDTH(pame_pkg::COEF_BITS), .DEPTH(pame_pkg::NEXP)) u_second (
    .clk(clk), .we(s_we), .waddr(fs_waddr), .wdata(fs_wdata), .raddr(fs_raddr), .rdata(s_q)
  );

  pame_ram #(.WIDTH(pame_pkg::TC_W), .DEPTH(pame_pkg::NPROD)) u_product (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_q)
  );

  pame_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .issue     ((state == pame_pkg::S_LDRUN) && ld_issue),
    .issue_addr(p_raddr),
    .d         (d),
    .other_q   (other_q),
    .prod_q    (p_q),
    .wr        (mac_wr),
    .active    (mac_active)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pame_pkg::S_CLR;
      clr_addr <= '0;
      prod_cur <= pame_pkg::PA_W'(pame_pkg::NPROD - 1);
      sum_cur  <= pame_pkg::FA_W'(pame_pkg::MAX_EXPONENT);
      valid    <= 1'b0;
      chk_v    <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        pame_pkg::S_IDLE: begin
          if (start) begin
            coef_q      <= c_in;
            exp_q       <= exponent;
            into_second <= (command == pame_pkg::CMD_LOAD_2);
            is_sum      <= (command == pame_pkg::CMD_READ_SUM);
            found       <= 1'b0;
            wrapped     <= 1'b0;
            chk_v       <= 1'b0;
            j           <= '0;
            unique case (command) inside
              pame_pkg::CMD_CLEAR: begin
                clr_addr <= '0;
                state    <= pame_pkg::S_CLR;
              end
              pame_pkg::CMD_LOAD_1, pame_pkg::CMD_LOAD_2: begin
                if (c_in != '0 && int'(exponent) <= pame_pkg::MAX_EXPONENT) begin
                  state <= pame_pkg::S_LDRD;
                end
              end
              pame_pkg::CMD_READ_PROD: begin
                ptr      <= pame_pkg::PTR_W'(prod_cur);
                can_wrap <= (int'(prod_cur) != pame_pkg::NPROD - 1);
                state    <= pame_pkg::S_SCAN;
              end
              pame_pkg::CMD_READ_SUM: begin
                ptr      <= pame_pkg::PTR_W'(sum_cur);
                can_wrap <= (int'(sum_cur) != pame_pkg::MAX_EXPONENT);
                state    <= pame_pkg::S_SCAN;
              end
              default: begin
              end
            endcase
          end
        end
        pame_pkg::S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (int'(clr_addr) == pame_pkg::NPROD - 1) begin
            prod_cur <= pame_pkg::PA_W'(pame_pkg::NPROD - 1);
            sum_cur  <= pame_pkg::FA_W'(pame_pkg::MAX_EXPONENT);
            state    <= pame_pkg::S_IDLE;
          end
        end
        pame_pkg::S_LDRD: begin
          state <= pame_pkg::S_LDD;
        end
        pame_pkg::S_LDD: begin
          d     <= pame_pkg::D_W'(coef_q) - pame_pkg::D_W'(mine_q);
          state <= pame_pkg::S_LDRUN;
        end
        pame_pkg::S_LDRUN: begin
          if (ld_issue) begin
            j <= j + 1'b1;
          end else if (!mac_active) begin
            state <= pame_pkg::S_IDLE;
          end
        end
        pame_pkg::S_SCAN: begin
          if (!ptr_neg) begin
            ptr      <= ptr - 1'b1;
            chk_v    <= 1'b1;
            chk_addr <= pame_pkg::PA_W'(ptr);
          end else begin
            chk_v <= 1'b0;
          end
          source <= is_sum;
          if (chk_v && chk_nz) begin
            if (!found) begin
              found     <= 1'b1;
              hold_coef <= chk_val;
              hold_exp  <= chk_addr;
            end else begin
              // another term below: not the last one
              valid            <= 1'b1;
              term_coefficient <= hold_coef;
              term_exponent    <= pame_pkg::TE_W'(hold_exp);
              last_term        <= 1'b0;
              empty_poly       <= 1'b0;
              if (is_sum) begin
                sum_cur <= pame_pkg::FA_W'(hold_exp - 1'b1);
              end else begin
                prod_cur <= hold_exp - 1'b1;
              end
              chk_v <= 1'b0;
              state <= pame_pkg::S_IDLE;
            end
          end else if (!chk_v && ptr_neg) begin
            if (found || wrapped || !can_wrap) begin
              valid            <= 1'b1;
              term_coefficient <= found ? hold_coef : '0;
              term_exponent    <= found ? pame_pkg::TE_W'(hold_exp) : '0;
              last_term        <= found;
              empty_poly       <= !found;
              if (is_sum) begin
                sum_cur <= pame_pkg::FA_W'(pame_pkg::MAX_EXPONENT);
              end else begin
                prod_cur <= pame_pkg::PA_W'(pame_pkg::NPROD - 1);
              end
              state <= pame_pkg::S_IDLE;
            end else begin
              wrapped <= 1'b1;
              ptr     <= is_sum ? pame_pkg::PTR_W'(pame_pkg::MAX_EXPONENT)
                                : pame_pkg::PTR_W'(pame_pkg::NPROD - 1);
            end
          end
        end
        default: begin
          state <= pame_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/pame_chk.sv =====
`timescale 1ns / 1ps
module pame_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic [pame_pkg::CMD_W-1:0]         command,
  input logic                               valid,
  input logic signed [pame_pkg::TC_W-1:0]   term_coefficient,
  input logic                               last_term,
  input logic                               empty_poly
);

  a_single_word: assert property (@(posedge clk) disable iff (rst)
    valid |=> !valid)
    else $error("back-to-back result words");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (valid && empty_poly) |-> (term_coefficient == '0 && !last_term))
    else $error("empty word carries a term");

  a_term_nonzero: assert property (@(posedge clk) disable iff (rst)
    (valid && !empty_poly) |-> (term_coefficient != '0))
    else $error("zero coefficient emitted");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == pame_pkg::CMD_READ_PROD ||
                        command == pame_pkg::CMD_READ_SUM)) |=> busy)
    else $error("read accepted without going busy");

  a_word_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(valid) |-> $past(busy))
    else $error("result word without preceding work");

endmodule

bind polynomial_add_multiply_engine pame_chk u_pame_chk (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .command         (command),
  .valid           (valid),
  .term_coefficient(term_coefficient),
  .last_term       (last_term),
  .empty_poly      (empty_poly)
);
